### hw/rtl/mplt_pkg.sv
package mplt_pkg;

    localparam int COORD_W    = 32;
    localparam int COEF_W     = 18;
    localparam int ROW_W      = 3 * COEF_W;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = DIFF_W + COEF_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int FRAC_W     = 16;
    localparam int RES_W      = SUM_W - FRAC_W + 1;
    localparam int AXES       = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_Z   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_MASK  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJ_VALID = 3'd7;

    localparam logic [ROW_W-1:0] COEF_ONE    = ROW_W'(65536);
    localparam logic [ROW_W-1:0] ROW_X_RESET = COEF_ONE;
    localparam logic [ROW_W-1:0] ROW_Y_RESET = COEF_ONE << COEF_W;
    localparam logic [ROW_W-1:0] ROW_Z_RESET = COEF_ONE << (2 * COEF_W);

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);
    localparam logic signed [RES_W-1:0] COORD_MAX  = RES_W'(32'sh7FFF_FFFF);
    localparam logic signed [RES_W-1:0] COORD_MIN  = -(RES_W'(33'sh0_8000_0000));

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [COORD_W-1:0]        vertex_flags;
        logic                      last_vertex;
    } vertex_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      was_transformed;
        logic                      saturated;
        logic                      last_out;
    } vertex_out_t;

endpackage

### hw/rtl/masked_pivot_linear_transform.sv
// Moves one vertex per clock cycle: while the object is enabled and the vertex flags hold every
// bit of the required mask, the position is turned by the 3x3 matrix about the pivot, otherwise
// it passes through unchanged. A transaction is taken at every clock edge at which start is high,
// since busy never rises. Its result passes through the four register stages (input, pivot
// difference, products, rounded sum) and is on result with done marking it for exactly one
// cycle, and results arrive in order at up to one per cycle. The receiver cannot stall the
// block, so it must take every result in the cycle that done marks. Configuration writes are
// always accepted and must only be made while no transaction is in flight.
module masked_pivot_linear_transform (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  mplt_pkg::vertex_in_t             vertex,
    output logic                             done,
    output mplt_pkg::vertex_out_t            result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mplt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mplt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mplt_pkg::*;

    logic [ROW_W-1:0]          row_reg [AXES];
    logic [ROW_W-1:0]          row_next [AXES];
    logic signed [COORD_W-1:0] piv_reg [AXES];
    logic signed [COORD_W-1:0] piv_next [AXES];
    logic [COORD_W-1:0]        mask_reg;
    logic [COORD_W-1:0]        mask_next;
    logic                      obj_valid_reg;
    logic                      obj_valid_next;

    logic                      in_valid_reg;
    logic                      in_valid_next;
    vertex_in_t                in_reg;

    logic                      diff_valid_reg;
    logic                      diff_valid_next;
    logic signed [DIFF_W-1:0]  diff_reg [AXES];
    logic signed [DIFF_W-1:0]  diff_next [AXES];
    logic                      diff_sel_reg;
    logic                      diff_sel_next;
    vertex_in_t                diff_vtx_reg;

    logic                      prod_valid_reg;
    logic                      prod_valid_next;
    logic signed [PROD_W-1:0]  prod_reg [AXES][AXES];
    logic signed [PROD_W-1:0]  prod_next [AXES][AXES];
    logic                      prod_sel_reg;
    vertex_in_t                prod_vtx_reg;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    vertex_out_t               out_reg;
    vertex_out_t               out_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = out_valid_reg;
    assign result    = out_reg;

    always_comb
    begin
        for (int r = 0; r < AXES; r++)
        begin
            row_next[r] = row_reg[r];
            piv_next[r] = piv_reg[r];
        end
        mask_next      = mask_reg;
        obj_valid_next = obj_valid_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROW_X:     row_next[0]    = cfg_data;
                CFG_ROW_Y:     row_next[1]    = cfg_data;
                CFG_ROW_Z:     row_next[2]    = cfg_data;
                CFG_PIVOT_X:   piv_next[0]    = cfg_data[COORD_W-1:0];
                CFG_PIVOT_Y:   piv_next[1]    = cfg_data[COORD_W-1:0];
                CFG_PIVOT_Z:   piv_next[2]    = cfg_data[COORD_W-1:0];
                CFG_REQ_MASK:  mask_next      = cfg_data[COORD_W-1:0];
                CFG_OBJ_VALID: obj_valid_next = cfg_data[0];
                default:       mask_next      = mask_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0]    <= ROW_X_RESET;
            row_reg[1]    <= ROW_Y_RESET;
            row_reg[2]    <= ROW_Z_RESET;
            for (int r = 0; r < AXES; r++)
            begin
                piv_reg[r] <= '0;
            end
            mask_reg      <= '0;
            obj_valid_reg <= 1'b1;
        end
        else
        begin
            row_reg       <= row_next;
            piv_reg       <= piv_next;
            mask_reg      <= mask_next;
            obj_valid_reg <= obj_valid_next;
        end
    end

    // The pivot differences are exact, so they need one bit more than a coordinate.
    always_comb
    begin
        in_valid_next   = start && !busy;
        diff_valid_next = in_valid_reg;
        prod_valid_next = diff_valid_reg;
        out_valid_next  = prod_valid_reg;
        diff_sel_next   = obj_valid_reg && ((in_reg.vertex_flags & mask_reg) == mask_reg);
        diff_next[0]    = DIFF_W'(in_reg.pos_x) - DIFF_W'(piv_reg[0]);
        diff_next[1]    = DIFF_W'(in_reg.pos_y) - DIFF_W'(piv_reg[1]);
        diff_next[2]    = DIFF_W'(in_reg.pos_z) - DIFF_W'(piv_reg[2]);
    end

    always_comb
    begin
        logic signed [COEF_W-1:0] coef;
        coef = '0;
        for (int r = 0; r < AXES; r++)
        begin
            for (int c = 0; c < AXES; c++)
            begin
                coef            = $signed(row_reg[r][c*COEF_W +: COEF_W]);
                prod_next[r][c] = PROD_W'(coef) * PROD_W'(diff_reg[c]);
            end
        end
    end

    // Rounding adds one half and drops the fraction with an arithmetic shift, which floors.
    always_comb
    begin
        logic signed [SUM_W-1:0]   acc;
        logic signed [RES_W-1:0]   moved;
        logic signed [COORD_W-1:0] coord [AXES];
        logic                      clip;
        acc  = '0;
        moved = '0;
        clip = 1'b0;
        for (int r = 0; r < AXES; r++)
        begin
            acc   = SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                  + SUM_W'(prod_reg[r][2]) + ROUND_HALF;
            moved = RES_W'($signed(acc[SUM_W-1:FRAC_W])) + RES_W'(piv_reg[r]);
            if (moved > COORD_MAX)
            begin
                coord[r] = COORD_MAX[COORD_W-1:0];
                clip     = 1'b1;
            end
            else if (moved < COORD_MIN)
            begin
                coord[r] = COORD_MIN[COORD_W-1:0];
                clip     = 1'b1;
            end
            else
            begin
                coord[r] = moved[COORD_W-1:0];
            end
        end
        if (prod_sel_reg)
        begin
            out_next.out_x     = coord[0];
            out_next.out_y     = coord[1];
            out_next.out_z     = coord[2];
            out_next.saturated = clip;
        end
        else
        begin
            out_next.out_x     = prod_vtx_reg.pos_x;
            out_next.out_y     = prod_vtx_reg.pos_y;
            out_next.out_z     = prod_vtx_reg.pos_z;
            out_next.saturated = 1'b0;
        end
        out_next.was_transformed = prod_sel_reg;
        out_next.last_out        = prod_vtx_reg.last_vertex;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            diff_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            diff_valid_reg <= diff_valid_next;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_next)
        begin
            in_reg <= vertex;
        end
        if (in_valid_reg)
        begin
            diff_reg     <= diff_next;
            diff_sel_reg <= diff_sel_next;
            diff_vtx_reg <= in_reg;
        end
        if (diff_valid_reg)
        begin
            prod_reg     <= prod_next;
            prod_sel_reg <= diff_sel_reg;
            prod_vtx_reg <= diff_vtx_reg;
        end
        if (prod_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("accepted transaction produced no result after four cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result produced without a matching accepted transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.was_transformed) |-> !result.saturated)
        else $error("saturation reported for a vertex that was not transformed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.was_transformed) |->
            (result.out_x == $past(vertex.pos_x, 4)) && (result.out_y == $past(vertex.pos_y, 4))
            && (result.out_z == $past(vertex.pos_z, 4)))
        else $error("unselected vertex was not passed through unchanged");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.last_out == $past(vertex.last_vertex, 4)))
        else $error("last-vertex mark lost on its way through the pipeline");
`endif

endmodule
